// ----- src/y2p_pkg.sv -----
`default_nettype none

package y2p_pkg;

    localparam int DEF_MAX_WIDTH  = 1920;
    localparam int DEF_MAX_HEIGHT = 1080;

    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 11;
    localparam int PCOL_W   = 10;
    localparam int PROW_W   = 11;
    localparam int IDATA_W  = 4 * SAMPLE_W;
    localparam int ODATA_W  = 56;
    localparam int CHROMA_W = 2 * SAMPLE_W;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic              odd;
        logic              last;
        logic [PCOL_W-1:0] col;
        logic [PROW_W-1:0] row;
    } pos_t;

endpackage

`default_nettype wire

// ----- src/y2p_ram.sv -----
`default_nettype none

module y2p_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 960
) (
    input  wire                   clk,
    input  wire                   we,
    input  wire                   re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire [WIDTH-1:0]       wdata,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/y2p_scan.sv -----
`default_nettype none

module y2p_scan
    import y2p_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire                   cfg_index,
    input  wire [CFG_W-1:0]       cfg_data,
    input  wire                   accept,
    input  wire [CHROMA_W-1:0]    chroma_in,
    output pos_t                  pos,
    output logic                  ram_we,
    output logic                  ram_re,
    output logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] ram_addr,
    output logic [CHROMA_W-1:0]   ram_wdata
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int COL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next, pairs_m1;
    logic [ROW_W-1:0] row_reg, row_next, rows_m1;
    logic [CFG_W-2:0] half;
    logic             odd, row_end, last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign half = width_reg[CFG_W-1:1];

    always_comb
    begin
        priority if (half == '0)
            pairs_m1 = '0;
        else if (32'(half) > DEPTH)
            pairs_m1 = COL_W'(DEPTH - 1);
        else
            pairs_m1 = COL_W'(half - 1'b1);

        priority if (height_reg < 11'd2)
            rows_m1 = ROW_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            rows_m1 = ROW_W'(MAX_HEIGHT - 1);
        else
            rows_m1 = ROW_W'(height_reg - 11'd1);
    end

    assign odd     = row_reg[0];
    assign row_end = (col_reg >= pairs_m1);
    assign last    = row_end && (row_reg >= rows_m1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.odd  = odd;
    assign pos.last = last;
    assign pos.col  = PCOL_W'(col_reg);
    assign pos.row  = PROW_W'(row_reg);

    assign ram_we    = accept && !odd;
    assign ram_re    = accept && odd;
    assign ram_addr  = col_reg;
    assign ram_wdata = chroma_in;

endmodule

`default_nettype wire

// ----- src/y2p_out.sv -----
`default_nettype none

module y2p_out
    import y2p_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   accept,
    output logic                  in_ready,
    input  wire [IDATA_W-1:0]     in_word,
    input  pos_t                  pos,
    input  wire [CHROMA_W-1:0]    rd_data,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [ODATA_W-1:0]    m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDATA_W-1:0] s1_word_reg;
    pos_t               s1_pos_reg;
    logic [ODATA_W-1:0] out_data_reg;
    logic               out_user_reg, out_last_reg;
    logic               move;
    logic [SAMPLE_W:0]  sum_b, sum_r;
    logic [SAMPLE_W-1:0] blue, red;
    logic [ODATA_W-1:0] word;

    assign move     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !s1_valid_reg || move;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // word: y0[7:0] cb[15:8] y1[23:16] cr[31:24]; store: cb low, cr high
    assign sum_b = {1'b0, rd_data[7:0]}  + {1'b0, s1_word_reg[15:8]};
    assign sum_r = {1'b0, rd_data[15:8]} + {1'b0, s1_word_reg[31:24]};
    assign blue  = s1_pos_reg.odd ? sum_b[SAMPLE_W:1] : '0;
    assign red   = s1_pos_reg.odd ? sum_r[SAMPLE_W:1] : '0;

    assign word = {3'b000, s1_pos_reg.row, s1_pos_reg.col, red, blue,
                   s1_word_reg[23:16], s1_word_reg[7:0]};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= in_word;
            s1_pos_reg  <= pos;
        end
        if (move)
        begin
            out_data_reg <= word;
            out_user_reg <= s1_pos_reg.odd;
            out_last_reg <= s1_pos_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- src/yuyv_to_planar_420_converter.sv -----
// YUYV 4:2:2 to planar 4:2:0 converter.
// Input stream: one packed pixel pair per word, raster order, on s_axis.
// Output stream: one word per input word on m_axis, carrying both luma
// samples, the vertically averaged chroma pair (odd rows only, tuser high),
// the pair column and row, and tlast on the last pair of the frame.
// Even rows store their chroma in a line buffer RAM indexed by pair column;
// odd rows read it back and average (sum halved, rounded down).
// Config: cfg_we/cfg_index/cfg_data write frame_width (0) or frame_height (1);
// write only while the block is idle.
// Pipeline: an accepted word is captured in the read stage, alongside the line
// buffer read, and then in the output register.
// Throughput: one word per cycle while m_axis_tready stays high, set by the
// single-port line buffer, which takes one read or one write per word.
// Reset: counters go to row 0 column 0, sizes to 640x480, the stream goes
// empty; the line buffer is not cleared (each entry is written on an even
// row before an odd row reads it).
// Receiver stall: the output word holds; one more word is held in the read
// stage, after which s_axis_tready drops until m_axis_tready returns.
`default_nettype none

module yuyv_to_planar_420_converter
    import y2p_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire [CFG_W-1:0]      cfg_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // luma_first, chroma_blue, luma_second, chroma_red
    input  wire [IDATA_W-1:0]    s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // luma_left_out, luma_right_out, blue_plane_sample, red_plane_sample,
    // pair_column, pixel_row, zero pad
    output logic [ODATA_W-1:0]   m_axis_tdata,
    // chroma_present
    output logic                 m_axis_tuser,
    // frame_end
    output logic                 m_axis_tlast
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                accept;
    pos_t                pos;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_addr;
    logic [CHROMA_W-1:0] ram_wdata, ram_rdata;

    assign accept = s_axis_tvalid && s_axis_tready;

    y2p_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .chroma_in ({s_axis_tdata[31:24], s_axis_tdata[15:8]}),
        .pos       (pos),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    y2p_ram #(
        .WIDTH (CHROMA_W),
        .DEPTH (DEPTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    y2p_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata),
        .pos      (pos),
        .rd_data  (ram_rdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- src/y2p_checker.sv -----
`default_nettype none

module y2p_checker
    import y2p_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  s_axis_tready,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [ODATA_W-1:0]    m_axis_tdata,
    input wire                  m_axis_tuser,
    input wire                  m_axis_tlast
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped under stall");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] == 16'd0)
        else $error("chroma nonzero on even row");

    a_chroma_odd_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser == m_axis_tdata[42])
        else $error("chroma flag does not match row parity");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind yuyv_to_planar_420_converter y2p_checker u_chk (.*);

`default_nettype wire
